FILE: rtl/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and codes for the circular deque block: command codes,
// controller states and the controller-to-datapath command group.
// ----------------------------------------------------------------------------
package cdq_pkg;

   // Field widths of the transaction payloads
   localparam int CMD_BITS  = 3;
   localparam int DATA_BITS = 32;
   localparam int POS_BITS  = 8;
   localparam int SLOT_BITS = 8;
   localparam int OCC_BITS  = 9;
   localparam int CAP_BITS  = 9;

   localparam int REQ_BITS  = CMD_BITS + DATA_BITS + POS_BITS;
   localparam int REQ_BYTES = (REQ_BITS + 7) / 8;
   localparam int RSP_BITS  = 1 + SLOT_BITS + DATA_BITS + OCC_BITS;
   localparam int RSP_BYTES = (RSP_BITS + 7) / 8;

   localparam int RESET_CAPACITY = 256;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_PUSH_BACK  = 3'd0,
      CMD_PUSH_FRONT = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_BACK   = 3'd3,
      CMD_PEEK       = 3'd4,
      CMD_CLEAR      = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_EXEC = 2'd1,
      ST_LOAD = 2'd2
   } state_type;

   // Strobes from the controller to the datapath
   typedef struct packed {
      logic capture;   // latch the accepted request
      logic execute;   // update pointers, access the ring memory
      logic load;      // move the result into the output register
   } ctl_type;

endpackage

FILE: rtl/circular_deque_with_index_read_unit.sv
// ----------------------------------------------------------------------------
// circular_deque_with_index_read_unit
// Double-ended ring buffer with push/pop at both ends, indexed peek and clear.
// ----------------------------------------------------------------------------
// Each request transaction carries one command and yields exactly one response
// transaction. A command passes through capture, execute and load in the unit,
// and the read data of the single-port ring memory is registered. The next
// request is accepted once the previous result sits in the output register, so
// the unit takes no new command before the last one is through. The ring needs
// no clearing pass after reset. A write on the csr channel sets the ring size
// (zero acts as one, values above DEPTH act as DEPTH) and empties the ring; it
// is only to be issued while no command is in flight.
module circular_deque_with_index_read_unit
   import cdq_pkg::*;
#(
   parameter int DEPTH     = 256,
   parameter int WORD_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   // command [2:0], item_data [34:3], position [42:35], zero fill above
   input  logic [REQ_BYTES*8-1:0] req_tdata,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // failed [0], slot [8:1], read_data [40:9], occupancy [49:41], zero fill above
   output logic [RSP_BYTES*8-1:0] rsp_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [CAP_BITS-1:0]    csr_data,
   input  logic                   csr_valid,
   output logic                   csr_ready
);

   ctl_type              ctl;
   logic                 failed;
   logic [SLOT_BITS-1:0] slot;
   logic [DATA_BITS-1:0] read_data;
   logic [OCC_BITS-1:0]  occupancy;

   assign csr_ready = 1'b1;

   cdq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .ctl        (ctl)
   );

   cdq_datapath #(
      .DEPTH     (DEPTH),
      .WORD_BITS (WORD_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .cmd       (req_tdata[CMD_BITS-1:0]),
      .item_data (req_tdata[CMD_BITS+DATA_BITS-1:CMD_BITS]),
      .position  (req_tdata[REQ_BITS-1:CMD_BITS+DATA_BITS]),
      .cap_write (csr_valid && csr_ready),
      .cap_data  (csr_data),
      .failed    (failed),
      .slot      (slot),
      .read_data (read_data),
      .occupancy (occupancy)
   );

   assign rsp_tdata = (RSP_BYTES*8)'({occupancy, read_data, slot, failed});

   // One command in flight: no new request right after an accepted one
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while a command is in flight");

   // A failed command reports neither a slot nor data
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && failed) |-> (slot == '0 && read_data == '0))
      else $error("failed response carries slot or data");

   // Response does not appear in the cycle right after acceptance
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !rsp_tvalid) |=> !$rose(rsp_tvalid))
      else $error("response raised too early");

endmodule

FILE: rtl/cdq_ctrl.sv
// ----------------------------------------------------------------------------
// cdq_ctrl
// Controller: sequences one command at a time through capture, execute and
// result load, and owns the request and response handshakes.
// ----------------------------------------------------------------------------
module cdq_ctrl
   import cdq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output ctl_type ctl
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      req_tready   = 1'b0;
      ctl          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ctl.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            ctl.execute = 1'b1;
            state_in    = ST_LOAD;
         end
         ST_LOAD: begin
            // wait until the output register is free or being drained
            if (!rsp_valid_ff || rsp_tready) begin
               ctl.load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

FILE: rtl/cdq_datapath.sv
// ----------------------------------------------------------------------------
// cdq_datapath
// Datapath: ring memory, head/tail pointers, item count, ring size and the
// output register of the result transaction.
// ----------------------------------------------------------------------------
module cdq_datapath
   import cdq_pkg::*;
#(
   parameter int DEPTH     = 256,
   parameter int WORD_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ctl_type              ctl,
   input  logic [CMD_BITS-1:0]  cmd,
   input  logic [DATA_BITS-1:0] item_data,
   input  logic [POS_BITS-1:0]  position,
   input  logic                 cap_write,
   input  logic [CAP_BITS-1:0]  cap_data,
   output logic                 failed,
   output logic [SLOT_BITS-1:0] slot,
   output logic [DATA_BITS-1:0] read_data,
   output logic [OCC_BITS-1:0]  occupancy
);

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int PW     = ((ADDR_W > POS_BITS) ? ADDR_W : POS_BITS) + 1;
   localparam int RESET_SIZE = (DEPTH < RESET_CAPACITY) ? DEPTH : RESET_CAPACITY;

   logic [WORD_BITS-1:0] mem [DEPTH];

   logic [CMD_BITS-1:0]  cmd_ff;
   logic [WORD_BITS-1:0] data_ff;
   logic [POS_BITS-1:0]  pos_ff;
   logic [ADDR_W-1:0]    head_ff, head_in;
   logic [ADDR_W-1:0]    tail_ff, tail_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     size_ff, size_in;
   logic [WORD_BITS-1:0] rdata_ff;

   logic                 res_failed_ff;
   logic [SLOT_BITS-1:0] res_slot_ff;
   logic [OCC_BITS-1:0]  res_occ_ff;
   logic                 res_rd_ff;

   logic                 rsp_failed_ff;
   logic [SLOT_BITS-1:0] rsp_slot_ff;
   logic [DATA_BITS-1:0] rsp_data_ff;
   logic [OCC_BITS-1:0]  rsp_occ_ff;

   logic                 fail;
   logic                 wr_en, rd_en;
   logic [ADDR_W-1:0]    addr;
   logic                 full, empty;
   logic [ADDR_W-1:0]    head_inc, head_dec, tail_inc, tail_dec;
   logic [PW-1:0]        peek_sum, peek_idx;
   logic [63:0]          data_wide;
   logic [63:0]          rdata_wide;
   logic [31:0]          addr_wide;
   logic [31:0]          count_wide;

   assign data_wide = 64'(item_data);

   // Request capture
   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         cmd_ff  <= cmd;
         data_ff <= data_wide[WORD_BITS-1:0];
         pos_ff  <= position;
      end
   end

   // Capacity clamp: zero acts as one, above the built depth acts as DEPTH
   always_comb begin
      if (cap_data == '0) begin
         size_in = CNT_W'(1);
      end else if (32'(cap_data) > 32'(DEPTH)) begin
         size_in = CNT_W'(DEPTH);
      end else begin
         size_in = CNT_W'(cap_data);
      end
   end

   assign full  = (count_ff >= size_ff);
   assign empty = (count_ff == '0);

   assign head_inc = ((CNT_W'(head_ff) + CNT_W'(1)) >= size_ff) ? '0 : head_ff + ADDR_W'(1);
   assign tail_inc = ((CNT_W'(tail_ff) + CNT_W'(1)) >= size_ff) ? '0 : tail_ff + ADDR_W'(1);
   assign head_dec = (head_ff == '0) ? ADDR_W'(size_ff - CNT_W'(1)) : head_ff - ADDR_W'(1);
   assign tail_dec = (tail_ff == '0) ? ADDR_W'(size_ff - CNT_W'(1)) : tail_ff - ADDR_W'(1);

   assign peek_sum = PW'(head_ff) + PW'(pos_ff);
   assign peek_idx = (peek_sum >= PW'(size_ff)) ? peek_sum - PW'(size_ff) : peek_sum;

   always_comb begin
      fail     = 1'b0;
      wr_en    = 1'b0;
      rd_en    = 1'b0;
      addr     = '0;
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      case (cmd_ff)
         CMD_PUSH_BACK: begin
            if (full) begin
               fail = 1'b1;
            end else begin
               wr_en    = 1'b1;
               addr     = tail_ff;
               tail_in  = tail_inc;
               count_in = count_ff + CNT_W'(1);
            end
         end
         CMD_PUSH_FRONT: begin
            if (full) begin
               fail = 1'b1;
            end else begin
               wr_en    = 1'b1;
               addr     = head_dec;
               head_in  = head_dec;
               count_in = count_ff + CNT_W'(1);
            end
         end
         CMD_POP_FRONT: begin
            if (empty) begin
               fail = 1'b1;
            end else begin
               rd_en    = 1'b1;
               addr     = head_ff;
               head_in  = head_inc;
               count_in = count_ff - CNT_W'(1);
            end
         end
         CMD_POP_BACK: begin
            if (empty) begin
               fail = 1'b1;
            end else begin
               rd_en    = 1'b1;
               addr     = tail_dec;
               tail_in  = tail_dec;
               count_in = count_ff - CNT_W'(1);
            end
         end
         CMD_PEEK: begin
            if (32'(pos_ff) >= 32'(count_ff)) begin
               fail = 1'b1;
            end else begin
               rd_en = 1'b1;
               addr  = peek_idx[ADDR_W-1:0];
            end
         end
         CMD_CLEAR: begin
            head_in  = '0;
            tail_in  = '0;
            count_in = '0;
         end
         default: fail = 1'b1;
      endcase
   end

   assign addr_wide  = 32'(addr);
   assign count_wide = 32'(count_in);

   // Pointer state; a capacity write empties the ring
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         size_ff  <= CNT_W'(RESET_SIZE);
      end else if (cap_write) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         size_ff  <= size_in;
      end else if (ctl.execute) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Ring memory, at most one access per command, registered read
   always_ff @(posedge clock) begin
      if (ctl.execute && wr_en) begin
         mem[addr] <= data_ff;
      end
      if (ctl.execute && rd_en) begin
         rdata_ff <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.execute) begin
         res_failed_ff <= fail;
         res_slot_ff   <= (wr_en || rd_en) ? addr_wide[SLOT_BITS-1:0] : '0;
         res_occ_ff    <= count_wide[OCC_BITS-1:0];
         res_rd_ff     <= rd_en;
      end
   end

   assign rdata_wide = 64'(rdata_ff);

   // Output register
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         rsp_failed_ff <= res_failed_ff;
         rsp_slot_ff   <= res_slot_ff;
         rsp_data_ff   <= res_rd_ff ? rdata_wide[DATA_BITS-1:0] : '0;
         rsp_occ_ff    <= res_occ_ff;
      end
   end

   assign failed    = rsp_failed_ff;
   assign slot      = rsp_slot_ff;
   assign read_data = rsp_data_ff;
   assign occupancy = rsp_occ_ff;

endmodule
